/* rtl/core/mpd_pkg.sv */
// Package for the MQTT packet deframer: result kinds, limits and the
// result/queue types shared by the modules. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mpd_pkg;

   // Longest remaining-length field, in bytes.
   localparam int MAX_LENGTH_BYTES = 4;

   // Result kinds
   localparam logic [2:0] KIND_TOPIC   = 3'd0;
   localparam logic [2:0] KIND_PAYLOAD = 3'd1;
   localparam logic [2:0] KIND_END     = 3'd2;
   localparam logic [2:0] KIND_CONNACK = 3'd3;
   localparam logic [2:0] KIND_LENERR  = 3'd4;

   // Control packet types from the fixed header
   localparam logic [3:0] TYPE_CONNACK = 4'd2;
   localparam logic [3:0] TYPE_PUBLISH = 4'd3;

   // Result queue geometry
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
      logic       connack_accepted;
      logic       last_of_run;
   } result_type;

   // Results produced by one accepted byte: zero, one or two of them.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

`default_nettype wire

/* rtl/core/mpd_if.sv */
// Valid/ready channel interfaces for the deframer: received bytes in,
// decoded results out. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface mpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] data;
   logic       connack_accepted;
   logic       last_of_run;

   modport source (output valid, output kind, output data, output connack_accepted,
                   output last_of_run, input ready);
   modport sink   (input valid, input kind, input data, input connack_accepted,
                   input last_of_run, output ready);
endinterface

`default_nettype wire

/* rtl/core/mpd_rsp_fifo.sv */
// Four-entry result queue that takes up to two results per cycle and
// drives the result channel from its head. Depends on mpd_pkg, mpd_if.
`timescale 1ns / 1ps
`default_nettype none

module mpd_rsp_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire mpd_pkg::push_type push_in,
   output logic                  room,
   mpd_rsp_if.source             rsp_bus
);

   mpd_pkg::result_type                  entry_ff [mpd_pkg::RSP_DEPTH];
   logic [mpd_pkg::RSP_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [mpd_pkg::RSP_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [mpd_pkg::RSP_CNT_W-1:0]        count_ff, count_in;
   logic                                 pop;
   mpd_pkg::result_type                  head;

   assign pop  = rsp_bus.valid && rsp_bus.ready;
   assign head = entry_ff[rd_ptr_ff];

   assign rsp_bus.valid            = (count_ff != '0);
   assign rsp_bus.kind             = head.kind;
   assign rsp_bus.data             = head.data;
   assign rsp_bus.connack_accepted = head.connack_accepted;
   assign rsp_bus.last_of_run      = head.last_of_run;

   // Room for a full pair, regardless of a pop in the same cycle.
   assign room = (count_ff <= mpd_pkg::RSP_CNT_W'(mpd_pkg::RSP_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + mpd_pkg::RSP_PTR_W'(push_in.count);
      rd_ptr_in = rd_ptr_ff + mpd_pkg::RSP_PTR_W'(pop);
      count_in  = count_ff + mpd_pkg::RSP_CNT_W'(push_in.count)
                  - mpd_pkg::RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_in.first;
      end
      if (push_in.count == 2'd2) begin
         entry_ff[wr_ptr_ff + mpd_pkg::RSP_PTR_W'(1)] <= push_in.second;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/mqtt_packet_deframer_core.sv */
// MQTT 3.1.1 receive deframer: parses a stream of back-to-back packets one
// byte per beat and queues the results. Depends on mpd_pkg, mpd_if, mpd_rsp_fifo.
//
// Usage: one received byte per req beat, at up to one beat per clock. Each
// accepted byte updates the parser state in the same cycle and lands its
// results (none, one or two) in a four-entry result queue; they are registered
// there before they show at the rsp port. req_bus.ready
// drops only while the queue holds more than two results, i.e. when the rsp
// side stalls or a run of two-result bytes outpaces the one-result-per-cycle
// drain. Results per byte: topic byte, payload byte, message end (PUBLISH),
// connack status (CONNACK, code 255 when the body is shorter than two bytes)
// and length error (remaining length longer than four bytes; the next byte is
// then taken as a fresh fixed header). last_of_run marks the final result of
// each byte. Other packet types are consumed silently.
`timescale 1ns / 1ps
`default_nettype none

module mqtt_packet_deframer_core (
   input  wire logic clock,
   input  wire logic reset,
   mpd_req_if.sink   req_bus,
   mpd_rsp_if.source rsp_bus
);

   // Parser phases
   localparam logic [2:0] PH_HEADER  = 3'd0;
   localparam logic [2:0] PH_LENGTH  = 3'd1;
   localparam logic [2:0] PH_SKIP    = 3'd2;
   localparam logic [2:0] PH_CONNACK = 3'd3;
   localparam logic [2:0] PH_TLEN_HI = 3'd4;
   localparam logic [2:0] PH_TLEN_LO = 3'd5;
   localparam logic [2:0] PH_TOPIC   = 3'd6;
   localparam logic [2:0] PH_PAYLOAD = 3'd7;

   logic [2:0]  phase_ff,        phase_in;
   logic [3:0]  packet_type_ff,  packet_type_in;
   logic [1:0]  qos_ff,          qos_in;
   logic [27:0] remaining_ff,    remaining_in;
   logic [1:0]  byte_index_ff,   byte_index_in;
   logic [7:0]  topic_hi_ff,     topic_hi_in;
   logic [15:0] topic_left_ff,   topic_left_in;
   logic [1:0]  id_skip_ff,      id_skip_in;
   logic        msg_valid_ff,    msg_valid_in;
   logic [7:0]  connack_code_ff, connack_code_in;

   logic                accept;
   logic                room;
   logic [7:0]          b;
   logic [27:0]         len_add;
   logic [27:0]         rem_dec;
   logic [15:0]         topic_len;
   logic                finish;
   logic                emit_valid;
   mpd_pkg::result_type emit_res;
   logic                fin_valid;
   mpd_pkg::result_type fin_res;
   mpd_pkg::push_type   push;

   assign b             = req_bus.rx_byte;
   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = room;

   // Seven-bit group of the length field placed at its position.
   always_comb begin
      unique case (byte_index_ff)
         2'd0: len_add = {21'b0, b[6:0]};
         2'd1: len_add = {14'b0, b[6:0], 7'b0};
         2'd2: len_add = {7'b0, b[6:0], 14'b0};
         2'd3: len_add = {b[6:0], 21'b0};
         default: len_add = '0;
      endcase
   end

   assign rem_dec   = remaining_ff - 28'd1;
   assign topic_len = {topic_hi_ff, b};

   always_comb begin
      // hold by default
      phase_in        = phase_ff;
      packet_type_in  = packet_type_ff;
      qos_in          = qos_ff;
      remaining_in    = remaining_ff;
      byte_index_in   = byte_index_ff;
      topic_hi_in     = topic_hi_ff;
      topic_left_in   = topic_left_ff;
      id_skip_in      = id_skip_ff;
      msg_valid_in    = msg_valid_ff;
      connack_code_in = connack_code_ff;
      finish          = 1'b0;
      emit_valid      = 1'b0;
      emit_res        = '0;

      unique case (phase_ff)
         PH_HEADER: begin
            packet_type_in  = b[7:4];
            qos_in          = b[2:1];
            remaining_in    = '0;
            byte_index_in   = '0;
            msg_valid_in    = 1'b0;
            connack_code_in = 8'hFF;
            phase_in        = PH_LENGTH;
         end
         PH_LENGTH: begin
            remaining_in = remaining_ff + len_add;
            if (b[7]) begin
               if ({1'b0, byte_index_ff} + 3'd1 >= 3'(mpd_pkg::MAX_LENGTH_BYTES)) begin
                  // overlong length field: report and resynchronize
                  phase_in       = PH_HEADER;
                  byte_index_in  = '0;
                  emit_valid     = 1'b1;
                  emit_res.kind  = mpd_pkg::KIND_LENERR;
               end else begin
                  byte_index_in = byte_index_ff + 2'd1;
               end
            end else begin
               byte_index_in = '0;
               if (remaining_in == '0) begin
                  finish = 1'b1;
               end else if (packet_type_ff == mpd_pkg::TYPE_CONNACK) begin
                  phase_in = PH_CONNACK;
               end else if (packet_type_ff == mpd_pkg::TYPE_PUBLISH) begin
                  phase_in = PH_TLEN_HI;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_CONNACK: begin
            if (byte_index_ff == 2'd1) begin
               connack_code_in = b;
            end
            if (byte_index_ff < 2'd2) begin
               byte_index_in = byte_index_ff + 2'd1;
            end
         end
         PH_TLEN_HI: begin
            topic_hi_in = b;
            phase_in    = PH_TLEN_LO;
         end
         PH_TLEN_LO: begin
            // this byte still counts in remaining, so the topic fits when len < remaining
            if ({12'b0, topic_len} < remaining_ff) begin
               msg_valid_in  = 1'b1;
               topic_left_in = topic_len;
               id_skip_in    = (qos_ff != 2'd0) ? 2'd2 : 2'd0;
               phase_in      = (topic_len != 16'd0) ? PH_TOPIC : PH_PAYLOAD;
            end else begin
               phase_in = PH_SKIP;
            end
         end
         PH_TOPIC: begin
            emit_valid    = 1'b1;
            emit_res.kind = mpd_pkg::KIND_TOPIC;
            emit_res.data = b;
            topic_left_in = topic_left_ff - 16'd1;
            if (topic_left_in == 16'd0) begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (id_skip_ff != 2'd0) begin
               id_skip_in = id_skip_ff - 2'd1;
            end else begin
               emit_valid    = 1'b1;
               emit_res.kind = mpd_pkg::KIND_PAYLOAD;
               emit_res.data = b;
            end
         end
         PH_SKIP: begin
         end
         default: begin
         end
      endcase

      // every body byte consumes one count of the remaining length
      if (phase_ff != PH_HEADER && phase_ff != PH_LENGTH) begin
         remaining_in = rem_dec;
         if (rem_dec == '0) begin
            finish = 1'b1;
         end
      end

      // end of packet: report and return to the fixed header
      fin_valid = 1'b0;
      fin_res   = '0;
      if (finish) begin
         if (packet_type_ff == mpd_pkg::TYPE_CONNACK) begin
            fin_valid                = 1'b1;
            fin_res.kind             = mpd_pkg::KIND_CONNACK;
            fin_res.data             = connack_code_in;
            fin_res.connack_accepted = (connack_code_in == 8'd0);
         end else if (packet_type_ff == mpd_pkg::TYPE_PUBLISH && msg_valid_in) begin
            fin_valid    = 1'b1;
            fin_res.kind = mpd_pkg::KIND_END;
         end
         msg_valid_in = 1'b0;
         phase_in     = PH_HEADER;
      end
   end

   // Pack the byte's results in order and flag the last one.
   always_comb begin
      push = '0;
      if (accept) begin
         if (emit_valid && fin_valid) begin
            push.count              = 2'd2;
            push.first              = emit_res;
            push.second             = fin_res;
            push.second.last_of_run = 1'b1;
         end else if (emit_valid) begin
            push.count             = 2'd1;
            push.first             = emit_res;
            push.first.last_of_run = 1'b1;
         end else if (fin_valid) begin
            push.count             = 2'd1;
            push.first             = fin_res;
            push.first.last_of_run = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         packet_type_ff  <= '0;
         qos_ff          <= '0;
         remaining_ff    <= '0;
         byte_index_ff   <= '0;
         topic_hi_ff     <= '0;
         topic_left_ff   <= '0;
         id_skip_ff      <= '0;
         msg_valid_ff    <= 1'b0;
         connack_code_ff <= 8'hFF;
      end else if (accept) begin
         phase_ff        <= phase_in;
         packet_type_ff  <= packet_type_in;
         qos_ff          <= qos_in;
         remaining_ff    <= remaining_in;
         byte_index_ff   <= byte_index_in;
         topic_hi_ff     <= topic_hi_in;
         topic_left_ff   <= topic_left_in;
         id_skip_ff      <= id_skip_in;
         msg_valid_ff    <= msg_valid_in;
         connack_code_ff <= connack_code_in;
      end
   end

   mpd_rsp_fifo u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .room    (room),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire
